// ----- rtl/core/bfdh_pkg.sv -----
// Package for the double-hash bloom filter: item and result types, operation
// codes, FSM state types and default sizes. No dependencies.

package bfdh_pkg;

	localparam int BIT_COUNT_DEF  = 65536;
	localparam int HASH_COUNT_DEF = 4;
	localparam int ROW_BITS       = 64;
	localparam int COL_W          = 6;
	localparam int QUEUE_DEPTH    = 4;
	localparam int SET_BITS_W     = 17;
	localparam int HASH_W         = 32;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                     operation;
		logic signed [HASH_W-1:0] primary_hash;
		logic signed [HASH_W-1:0] secondary_hash;
	} item_t;

	typedef struct packed {
		logic                  found;
		logic [SET_BITS_W-1:0] set_bits;
	} result_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_PROBE,
		F_REDUCE,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_MODIFY
	} back_state_t;

endpackage

// ----- rtl/core/bfdh_fifo.sv -----
// Short probe queue between the index front end and the bit-store back end.
// Depends on nothing but its parameters.

module bfdh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/bfdh_front.sv -----
// Front end: takes an item, walks its probe sums and reduces each to a bit
// index, then queues {last, op, index}. Depends on bfdh_pkg.

module bfdh_front #(
	parameter int BIT_COUNT  = bfdh_pkg::BIT_COUNT_DEF,
	parameter int HASH_COUNT = bfdh_pkg::HASH_COUNT_DEF,
	parameter int IDX_W      = $clog2(BIT_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  bfdh_pkg::item_t      item,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [IDX_W+1:0]     q_data
);

	localparam int  HW      = bfdh_pkg::HASH_W;
	localparam int  QSH     = HW - 1 + IDX_W;
	localparam int  HC_W    = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
	localparam bit  POW2    = ((64'd1 << IDX_W) == 64'(BIT_COUNT));
	localparam logic [HW-1:0] RECIP   = HW'((64'd1 << QSH) / 64'(BIT_COUNT));
	localparam logic [HW-1:0] DIVISOR = HW'(BIT_COUNT);
	localparam logic [1:0] RED_MUL  = 2'd0;
	localparam logic [1:0] RED_BACK = 2'd1;
	localparam logic [1:0] RED_FIX  = 2'd2;

	bfdh_pkg::front_state_t state_q, state_d;

	logic [HW-1:0]   sum_q;
	logic [HW-1:0]   h2_q;
	logic            op_q;
	logic [HC_W-1:0] cnt_q;
	logic [HW-1:0]   rem_q;
	logic [HW-1:0]   quo_q;
	logic [1:0]      step_q;
	logic [HW-1:0]   mag;
	logic [2*HW-1:0] prod;
	logic            last;

	assign mag  = sum_q[HW-1] ? (~sum_q + 1'b1) : sum_q;
	assign last = (cnt_q == HC_W'(HASH_COUNT - 1));
	assign prod = (2*HW)'(rem_q) * (2*HW)'(RECIP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfdh_pkg::F_IDLE:   if (accept) state_d = bfdh_pkg::F_PROBE;
			bfdh_pkg::F_PROBE:  state_d = POW2 ? bfdh_pkg::F_PUSH : bfdh_pkg::F_REDUCE;
			bfdh_pkg::F_REDUCE: if (step_q == RED_FIX) state_d = bfdh_pkg::F_PUSH;
			bfdh_pkg::F_PUSH: begin
				if (!q_full) begin
					state_d = last ? bfdh_pkg::F_IDLE : bfdh_pkg::F_PROBE;
				end
			end
			default:            state_d = bfdh_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		q_push = 1'b0;
		q_data = {last, op_q, rem_q[IDX_W-1:0]};
		case (state_q)
			bfdh_pkg::F_PUSH: q_push = !q_full;
			default:          q_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfdh_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bfdh_pkg::F_IDLE: begin
				if (accept) begin
					sum_q <= item.primary_hash;
					h2_q  <= item.secondary_hash;
					op_q  <= item.operation;
					cnt_q <= '0;
				end
			end
			bfdh_pkg::F_PROBE: begin
				rem_q  <= mag;
				step_q <= RED_MUL;
			end
			bfdh_pkg::F_REDUCE: begin
				case (step_q)
					RED_MUL:  quo_q <= HW'(prod >> QSH);
					RED_BACK: rem_q <= rem_q - quo_q * DIVISOR;
					RED_FIX: begin
						if (rem_q >= DIVISOR) begin
							rem_q <= rem_q - DIVISOR;
						end
					end
					default:  quo_q <= quo_q;
				endcase
				step_q <= step_q + 1'b1;
			end
			bfdh_pkg::F_PUSH: begin
				if (!q_full) begin
					sum_q <= sum_q + h2_q;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

endmodule

// ----- rtl/core/bfdh_back.sv -----
// Back end: clears the bit store after reset, then runs a read-modify-write
// per queued probe and emits one result per item. Depends on bfdh_pkg.

module bfdh_back #(
	parameter int BIT_COUNT = bfdh_pkg::BIT_COUNT_DEF,
	parameter int IDX_W     = $clog2(BIT_COUNT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W+1:0]      q_data,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  done,
	output bfdh_pkg::result_t     result,
	output bfdh_pkg::back_status_t status
);

	localparam int RB     = bfdh_pkg::ROW_BITS;
	localparam int CB     = bfdh_pkg::COL_W;
	localparam int ROWS   = (BIT_COUNT + RB - 1) / RB;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W  = $clog2(BIT_COUNT + 1);

	bfdh_pkg::back_state_t state_q, state_d;

	logic [RB-1:0]     mem [ROWS];
	logic [RB-1:0]     rd_q;
	logic [ROW_AW-1:0] clr_q;
	logic [IDX_W+1:0]  pr_s1;
	logic [CNT_W-1:0]  ones_q;
	logic              all_q;
	logic              done_q;
	bfdh_pkg::result_t res_q;

	logic              mem_we;
	logic [ROW_AW-1:0] mem_addr;
	logic [RB-1:0]     mem_wdata;
	logic [31:0]       head_row;
	logic [31:0]       pr_row;
	logic [CB-1:0]     col;
	logic              hit;
	logic              pr_op;
	logic              pr_last;
	logic              set_new;
	logic [CNT_W-1:0]  ones_next;

	assign head_row  = 32'(q_data[IDX_W-1:0]) >> CB;
	assign pr_row    = 32'(pr_s1[IDX_W-1:0]) >> CB;
	assign col       = pr_s1[CB-1:0];
	assign pr_op     = pr_s1[IDX_W];
	assign pr_last   = pr_s1[IDX_W+1];
	assign hit       = rd_q[col];
	assign set_new   = (pr_op == bfdh_pkg::OP_ADD) && !hit;
	assign ones_next = set_new ? ones_q + 1'b1 : ones_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfdh_pkg::B_CLEAR:  if (clr_q == ROW_AW'(ROWS - 1)) state_d = bfdh_pkg::B_IDLE;
			bfdh_pkg::B_IDLE:   if (!q_empty) state_d = bfdh_pkg::B_MODIFY;
			bfdh_pkg::B_MODIFY: state_d = bfdh_pkg::B_IDLE;
			default:            state_d = bfdh_pkg::B_CLEAR;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pr_row[ROW_AW-1:0];
		mem_wdata = rd_q | (RB'(1) << col);
		case (state_q)
			bfdh_pkg::B_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			bfdh_pkg::B_IDLE: begin
				q_pop    = !q_empty;
				mem_addr = head_row[ROW_AW-1:0];
			end
			bfdh_pkg::B_MODIFY: begin
				mem_we = set_new;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == bfdh_pkg::B_IDLE && !q_empty) begin
			pr_s1 <= q_data;
		end
		if (state_q == bfdh_pkg::B_MODIFY && pr_last) begin
			res_q.found    <= (pr_op == bfdh_pkg::OP_QUERY) && all_q && hit;
			res_q.set_bits <= bfdh_pkg::SET_BITS_W'(ones_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfdh_pkg::B_CLEAR;
			clr_q   <= '0;
			ones_q  <= '0;
			all_q   <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == bfdh_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == bfdh_pkg::B_MODIFY) begin
				ones_q <= ones_next;
				if (pr_last) begin
					all_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					all_q <= all_q && hit;
				end
			end
		end
	end

	assign done            = done_q;
	assign result          = res_q;
	assign status.clearing = (state_q == bfdh_pkg::B_CLEAR);

	a_done_after_modify: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == bfdh_pkg::B_MODIFY))
		else $error("result without a final probe");

	a_found_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfdh_pkg::B_MODIFY && pr_op == bfdh_pkg::OP_ADD) |=> !(done_q && res_q.found))
		else $error("add reported found");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= CNT_W'(BIT_COUNT))
		else $error("set bit count above store size");

endmodule

// ----- rtl/core/bloom_filter_double_hash.sv -----
// Top level of the double-hash bloom filter: front end, probe queue, back end.
// Depends on bfdh_pkg, bfdh_front, bfdh_fifo, bfdh_back.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+------------------------------------
//  item in  | start, busy, item     | taken at edge with start && !busy
//  result   | done, result          | done high one cycle, always taken
//
// One item at a time. Each probe passes through the back end as a row read,
// then a write, and through the front end as probe then push, with a
// reciprocal multiply, back-multiply and correction between them unless
// BIT_COUNT is a power of two; the queue overlaps the two ends. Busy drops
// the cycle after done. After reset busy stays high while the back end clears
// the ceil(BIT_COUNT/64) store rows (1024 by default). No receiver stall.

module bloom_filter_double_hash #(
	parameter int BIT_COUNT  = bfdh_pkg::BIT_COUNT_DEF,
	parameter int HASH_COUNT = bfdh_pkg::HASH_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfdh_pkg::item_t   item,
	output logic              done,
	output bfdh_pkg::result_t result
);

	localparam int IDX_W = $clog2(BIT_COUNT);
	localparam int QW    = IDX_W + 2;

	logic                   accept;
	logic                   inflight_q;
	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [QW-1:0]          q_wdata;
	logic [QW-1:0]          q_rdata;
	bfdh_pkg::back_status_t st;

	assign busy   = st.clearing || inflight_q;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 1'b0;
		end else if (accept) begin
			inflight_q <= 1'b1;
		end else if (done) begin
			inflight_q <= 1'b0;
		end
	end

	bfdh_front #(
		.BIT_COUNT  (BIT_COUNT),
		.HASH_COUNT (HASH_COUNT),
		.IDX_W      (IDX_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	bfdh_fifo #(
		.WIDTH (QW),
		.DEPTH (bfdh_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bfdh_back #(
		.BIT_COUNT (BIT_COUNT),
		.IDX_W     (IDX_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result),
		.status  (st)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item not marked busy");

	a_done_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> inflight_q)
		else $error("result with no item in flight");

	a_no_item_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> (!inflight_q && q_empty))
		else $error("item in flight during store clear");

endmodule
